// ===== rtl/mf5_pkg.sv =====
package mf5_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int WREG_W      = 12;
	localparam int HEIGHT_W    = 16;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int EW          = $clog2(MAX_WIDTH + 1);
	localparam int POS_W       = COL_W + HEIGHT_W + 1;
	localparam int CFG_DATA_W  = 16;
	localparam int TAPS        = 25;
	localparam int RANK_W      = 5;
	localparam int MEDIAN_RANK = 12;
	localparam int CHAN        = 3;
	localparam int BITS        = 8;
	localparam int FIFO_DEPTH  = 16;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [3*BITS-1:0] rgb_t;
	typedef logic [TAPS-1:0][3*BITS-1:0] taps_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] blue_out;
		logic [7:0] green_out;
		logic [7:0] red_out;
		logic       last_pixel;
	} pix_out_t;

	typedef struct packed {
		logic interior;
		logic last;
	} tag_t;

endpackage

// ===== rtl/mf5_median.sv =====
module mf5_median
	import mf5_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     win_valid,
	input  taps_t    win_taps,
	input  tag_t     win_tag,
	output logic     med_valid,
	output pix_out_t med_pix
);

	logic [BITS:0] vld_s;
	tag_t          tag_s [BITS+1];
	taps_t         val_s [BITS+1];
	logic [TAPS-1:0]   act_s [BITS+1][CHAN];
	logic [RANK_W-1:0] k_s   [BITS+1][CHAN];
	logic [BITS-1:0]   res_s [BITS+1][CHAN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= win_valid;
		end
	end

	always_ff @(posedge clk) begin
		val_s[0] <= win_taps;
		tag_s[0] <= win_tag;
		for (int ch = 0; ch < CHAN; ch++) begin
			act_s[0][ch] <= '1;
			k_s[0][ch]   <= RANK_W'(MEDIAN_RANK);
			res_s[0][ch] <= '0;
		end
	end

	for (genvar s = 1; s <= BITS; s++) begin : g_bit
		logic [TAPS-1:0]   ones    [CHAN];
		logic [RANK_W-1:0] zeros   [CHAN];
		logic [TAPS-1:0]   nxt_act [CHAN];
		logic [RANK_W-1:0] nxt_k   [CHAN];
		logic [BITS-1:0]   nxt_res [CHAN];

		always_comb begin
			for (int ch = 0; ch < CHAN; ch++) begin
				for (int j = 0; j < TAPS; j++) begin
					ones[ch][j] = val_s[s-1][j][ch*BITS + (BITS-s)];
				end
				zeros[ch]   = RANK_W'($countones(act_s[s-1][ch] & ~ones[ch]));
				nxt_res[ch] = res_s[s-1][ch];
				if (k_s[s-1][ch] < zeros[ch]) begin
					nxt_act[ch]            = act_s[s-1][ch] & ~ones[ch];
					nxt_k[ch]              = k_s[s-1][ch];
					nxt_res[ch][BITS-s]    = 1'b0;
				end else begin
					nxt_act[ch]            = act_s[s-1][ch] & ones[ch];
					nxt_k[ch]              = k_s[s-1][ch] - zeros[ch];
					nxt_res[ch][BITS-s]    = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else begin
				vld_s[s] <= vld_s[s-1];
			end
		end

		always_ff @(posedge clk) begin
			val_s[s] <= val_s[s-1];
			tag_s[s] <= tag_s[s-1];
			for (int ch = 0; ch < CHAN; ch++) begin
				act_s[s][ch] <= nxt_act[ch];
				k_s[s][ch]   <= nxt_k[ch];
				res_s[s][ch] <= nxt_res[ch];
			end
		end
	end

	rgb_t centre;

	always_comb begin
		centre    = val_s[BITS][TAPS/2];
		med_valid = vld_s[BITS];
		med_pix.last_pixel = tag_s[BITS].last;
		if (tag_s[BITS].interior) begin
			med_pix.blue_out  = res_s[BITS][0];
			med_pix.green_out = res_s[BITS][1];
			med_pix.red_out   = res_s[BITS][2];
		end else begin
			med_pix.blue_out  = centre[7:0];
			med_pix.green_out = centre[15:8];
			med_pix.red_out   = centre[23:16];
		end
	end

endmodule

// ===== rtl/median_filter_5x5_rgb_top.sv =====
// Channel  Handshake              Payload
// pix      pix_valid/pix_stall    pix_in_t: mode, blue, green, red
// res      res_valid/res_stall    pix_out_t: blue_out, green_out, red_out, last_pixel
// cfg      cfg_we                 cfg_index, cfg_data
// One pixel transaction is taken per clock while pix_stall is low.
// The rate is set by the single line store memory, read and written once per pixel.
// Reset clears all counters and the output queue; the line store has no clearing pass.
// A sixteen-entry output queue absorbs result stalls; pix_stall rises when all its entries are committed.
module median_filter_5x5_rgb_top
	import mf5_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_in_t               pix,
	output logic                  res_valid,
	input  logic                  res_stall,
	output pix_out_t              res,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [WREG_W-1:0]   image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;
	logic [POS_W-1:0]    total_q;
	logic [POS_W-1:0]    thr_q;
	logic [POS_W-1:0]    pos_q;
	logic [COL_W-1:0]    in_col_q;
	logic [COL_W-1:0]    out_col_q;
	logic [HEIGHT_W-1:0] out_row_q;

	logic [EW-1:0]       w_eff;
	logic [EW-1:0]       w_new;
	logic                pix_acc;
	logic                step;
	logic                produce;
	logic                pos_lt;
	logic [EW:0]         col_next;
	logic [EW:0]         ocol_next;
	logic                in_wrap;
	logic                out_wrap;
	tag_t                tag_now;
	rgb_t                pix_now;

	always_comb begin
		if (int'(image_width_q) > MAX_WIDTH) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(image_width_q);
		end
		if (int'(cfg_data[WREG_W-1:0]) > MAX_WIDTH) begin
			w_new = EW'(MAX_WIDTH);
		end else begin
			w_new = EW'(cfg_data[WREG_W-1:0]);
		end
		pix_acc   = pix_valid && !pix_stall;
		pos_lt    = pos_q < total_q;
		step      = pix_acc && (w_eff != '0) && (image_height_q != '0) && !(pos_lt && pix.mode);
		produce   = step && (pos_q >= thr_q);
		col_next  = (EW+1)'(in_col_q) + 1'b1;
		ocol_next = (EW+1)'(out_col_q) + 1'b1;
		in_wrap   = col_next >= (EW+1)'(w_eff);
		out_wrap  = ocol_next >= (EW+1)'(w_eff);
		tag_now.interior = (out_row_q >= HEIGHT_W'(2)) &&
			((HEIGHT_W+1)'(out_row_q) + 2'd2 < (HEIGHT_W+1)'(image_height_q)) &&
			(out_col_q >= COL_W'(2)) &&
			((EW+1)'(out_col_q) + 2'd2 < (EW+1)'(w_eff));
		tag_now.last = ((HEIGHT_W+1)'(out_row_q) + 1'b1 == (HEIGHT_W+1)'(image_height_q)) &&
			(ocol_next == (EW+1)'(w_eff));
		pix_now = pos_lt ? {pix.red, pix.green, pix.blue} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WREG_W'(RESET_WIDTH);
			image_height_q <= HEIGHT_W'(RESET_HEIGHT);
			total_q        <= POS_W'(RESET_WIDTH * RESET_HEIGHT);
			thr_q          <= POS_W'(2 * RESET_WIDTH + 2);
			pos_q          <= '0;
			in_col_q       <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[WREG_W-1:0];
					total_q       <= POS_W'(w_new) * POS_W'(image_height_q);
					thr_q         <= POS_W'({w_new, 1'b0}) + POS_W'(2);
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[HEIGHT_W-1:0];
					total_q        <= POS_W'(w_eff) * POS_W'(cfg_data[HEIGHT_W-1:0]);
				end
				default: begin
				end
			endcase
			pos_q     <= '0;
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (step) begin
			if (produce && tag_now.last) begin
				pos_q     <= '0;
				in_col_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				pos_q    <= pos_q + 1'b1;
				in_col_q <= in_wrap ? '0 : COL_W'(col_next);
				if (produce) begin
					if (out_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						out_col_q <= COL_W'(ocol_next);
					end
				end
			end
		end
	end

	// Line store: four rows per word, newest row in the low bits.
	logic [4*3*BITS-1:0] line_mem [MAX_WIDTH];
	logic [4*3*BITS-1:0] rd_data_q;
	logic [4*3*BITS-1:0] fwd_data_q;
	logic [4*3*BITS-1:0] rd_word;
	logic [4*3*BITS-1:0] wr_data;

	logic             valid_s1;
	logic             produce_s1;
	logic             fwd_s1;
	logic [COL_W-1:0] col_s1;
	rgb_t             pix_s1;
	tag_t             tag_s1;
	logic             go_s2;
	tag_t             tag_s2;

	rgb_t  win_q [5][5];
	taps_t taps;

	always_comb begin
		rd_word = fwd_s1 ? fwd_data_q : rd_data_q;
		wr_data = {rd_word[71:0], pix_s1};
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 5; j++) begin
				taps[i*5+j] = win_q[i][j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rd_data_q <= line_mem[in_col_q];
		end
		if (valid_s1) begin
			line_mem[col_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			produce_s1 <= 1'b0;
			fwd_s1     <= 1'b0;
			go_s2      <= 1'b0;
		end else begin
			valid_s1   <= step;
			produce_s1 <= produce;
			fwd_s1     <= step && valid_s1 && (in_col_q == col_s1);
			go_s2      <= valid_s1 && produce_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_s1     <= in_col_q;
		pix_s1     <= pix_now;
		tag_s1     <= tag_now;
		tag_s2     <= tag_s1;
		fwd_data_q <= wr_data;
		if (valid_s1) begin
			for (int i = 0; i < 5; i++) begin
				for (int j = 0; j < 4; j++) begin
					win_q[i][j] <= win_q[i][j+1];
				end
			end
			win_q[0][4] <= rd_word[95:72];
			win_q[1][4] <= rd_word[71:48];
			win_q[2][4] <= rd_word[47:24];
			win_q[3][4] <= rd_word[23:0];
			win_q[4][4] <= pix_s1;
		end
	end

	logic     med_valid;
	pix_out_t med_pix;

	mf5_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (go_s2),
		.win_taps  (taps),
		.win_tag   (tag_s2),
		.med_valid (med_valid),
		.med_pix   (med_pix)
	);

	pix_out_t           fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   fill_q;
	logic [FIFO_AW:0]   commit_q;
	logic               pop;

	always_comb begin
		res_valid = fill_q != '0;
		res       = fifo_q[rd_ptr_q];
		pop       = res_valid && !res_stall;
		pix_stall = commit_q >= (FIFO_AW+1)'(FIFO_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (med_valid) begin
			fifo_q[wr_ptr_q] <= med_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			commit_q <= '0;
		end else begin
			if (med_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q   <= fill_q + (FIFO_AW+1)'(med_valid) - (FIFO_AW+1)'(pop);
			commit_q <= commit_q + (FIFO_AW+1)'(produce) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

// ===== rtl/mf5_checker.sv =====
module mf5_checker
	import mf5_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pix_valid,
	input logic                  pix_stall,
	input pix_in_t               pix,
	input logic                  res_valid,
	input logic                  res_stall,
	input pix_out_t              res,
	input logic                  cfg_we,
	input logic [0:0]            cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// A stalled result transaction keeps its valid and its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result transaction changed while stalled");

	// The input only stalls when committed results are already waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid)
		else $error("input stalled with no result waiting");

	// Reset empties the output queue.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !res_valid)
		else $error("result valid right after reset");

	// A configuration write right after an idle input never meets a blocked input while no result is offered.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && !$past(pix_valid) |-> !(pix_valid && pix_stall) || res_valid)
		else $error("configuration write while input blocked without output");

endmodule

bind median_filter_5x5_rgb_top mf5_checker u_mf5_checker (.*);

// ===== bench/mf5_checker.sv =====
`timescale 1ns / 100ps
module mf5_scoreboard
	import mf5_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	input  logic                  pix_stall,
	input  pix_in_t               pix,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  pix_out_t              res,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);

	logic [23:0] lines [4][MAX_WIDTH];
	logic [23:0] win [5][5];
	int unsigned wid_reg, hgt_reg;
	int unsigned icol, irow, ocol, orow;
	pix_out_t    filtered_q[$];

	function automatic logic [7:0] channel_median(int sh);
		logic [7:0] v[25];
		int n, lt, le;
		n = 0;
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++) begin
				v[n] = win[i][j][sh +: 8];
				n++;
			end
		for (int i = 0; i < 25; i++) begin
			lt = 0;
			le = 0;
			for (int j = 0; j < 25; j++) begin
				if (v[j] < v[i])
					lt++;
				if (v[j] <= v[i])
					le++;
			end
			if (lt <= MEDIAN_RANK && le > MEDIAN_RANK)
				return v[i];
		end
		return 8'd0;
	endfunction

	task automatic filter_pixel(pix_in_t p);
		longint unsigned w, h, total, pos;
		logic [23:0] px, r0, r1, r2, r3, c;
		int unsigned col;
		pix_out_t o;
		bit interior, last;
		w = (wid_reg > MAX_WIDTH) ? MAX_WIDTH : wid_reg;
		h = hgt_reg;
		if (w == 0 || h == 0)
			return;
		total = w * h;
		pos = irow * w + icol;
		if (pos < total) begin
			if (p.mode)
				return;
			px = {p.red, p.green, p.blue};
		end else begin
			px = '0;
		end
		col = (icol < MAX_WIDTH) ? icol : 0;
		r0 = lines[0][col];
		r1 = lines[1][col];
		r2 = lines[2][col];
		r3 = lines[3][col];
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 4; j++)
				win[i][j] = win[i][j+1];
		win[0][4] = r3;
		win[1][4] = r2;
		win[2][4] = r1;
		win[3][4] = r0;
		win[4][4] = px;
		lines[3][col] = r2;
		lines[2][col] = r1;
		lines[1][col] = r0;
		lines[0][col] = px;
		icol++;
		if (icol >= w) begin
			icol = 0;
			irow++;
		end
		if (pos < 2 * w + 2)
			return;
		interior = orow >= 2 && orow + 2 < h && ocol >= 2 && ocol + 2 < w;
		c = win[2][2];
		if (interior) begin
			o.blue_out  = channel_median(0);
			o.green_out = channel_median(8);
			o.red_out   = channel_median(16);
		end else begin
			o.blue_out  = c[7:0];
			o.green_out = c[15:8];
			o.red_out   = c[23:16];
		end
		last = (orow + 1 == h) && (ocol + 1 == w);
		o.last_pixel = last;
		filtered_q.push_back(o);
		if (last) begin
			icol = 0;
			irow = 0;
			ocol = 0;
			orow = 0;
		end else begin
			ocol++;
			if (ocol >= w) begin
				ocol = 0;
				orow++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_out_t e;
		if (!arst_n) begin
			wid_reg = RESET_WIDTH;
			hgt_reg = RESET_HEIGHT;
			icol = 0;
			irow = 0;
			ocol = 0;
			orow = 0;
			filtered_q.delete();
			errors = 0;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < MAX_WIDTH; j++)
					lines[i][j] = '0;
			for (int i = 0; i < 5; i++)
				for (int j = 0; j < 5; j++)
					win[i][j] = '0;
		end else begin
			if (res_valid && !res_stall) begin
				if (filtered_q.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, res);
					errors++;
				end else begin
					e = filtered_q.pop_front();
					if (e !== res) begin
						$display("%0t: result mismatch, expected %h actual %h", $time, e, res);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH)
					wid_reg = 32'(cfg_data[WREG_W-1:0]);
				else
					hgt_reg = 32'(cfg_data);
				icol = 0;
				irow = 0;
				ocol = 0;
				orow = 0;
			end
			if (pix_valid && !pix_stall)
				filter_pixel(pix);
		end
		pending = filtered_q.size();
	end

endmodule

// ===== bench/tb_median_filter_5x5_rgb_top.sv =====
`timescale 1ns / 100ps
module tb_median_filter_5x5_rgb_top;
	import mf5_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	pix_in_t               pix = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	pix_out_t              res;
	logic                  cfg_we = 1'b0;
	logic [0:0]            cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    errors;
	int                    pending;
	bit                    hold_off = 1'b0;

	always #1 clk = ~clk;

	median_filter_5x5_rgb_top i_dut (.*);

	mf5_scoreboard i_checker (.*);

	task automatic send_pixel(bit flush, bit [23:0] rgb);
		pix_valid <= 1'b1;
		pix <= '{mode: flush, blue: rgb[7:0], green: rgb[15:8], red: rgb[23:16]};
		do
			@(posedge clk);
		while (pix_stall);
	endtask

	task automatic idle_gap(int n);
		pix_valid <= 1'b0;
		repeat (n)
			@(posedge clk);
	endtask

	task automatic drain_out();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_size(int unsigned w, int unsigned h);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	function automatic bit [23:0] rand_rgb();
		case ($urandom_range(0, 5))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return {$urandom_range(0, 3) == 0 ? 8'hFF : 8'h00, 16'($urandom)};
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_frame(int unsigned w, int unsigned h, bit bursty, bit noisy);
		int unsigned burst;
		burst = $urandom_range(1, 30);
		for (int k = 0; k < w * h + 2 * w + 2; k++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_pixel(1'b1, rand_rgb());
			send_pixel(k >= w * h ? ($urandom_range(0, 3) != 0) : 1'b0, rand_rgb());
			if (bursty) begin
				burst--;
				if (burst == 0) begin
					idle_gap($urandom_range(1, 6));
					burst = $urandom_range(1, 30);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_off)
			res_stall <= 1'b1;
		else
			case ($urandom_range(0, 3))
				0: res_stall <= ($urandom_range(0, 1) == 1);
				1: res_stall <= ($urandom_range(0, 9) == 0);
				default: res_stall <= 1'b0;
			endcase
	end

	initial begin
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_size(5, 5);
		for (int k = 0; k < 4; k++)
			send_pixel(1'b0, (k % 2) ? 24'hFFFFFF : 24'h000000);
		send_pixel(1'b1, 24'h0);
		for (int k = 4; k < 25; k++)
			send_pixel(1'b0, (k % 3) ? 24'hFFFFFF : 24'h000000);
		send_pixel(1'b0, 24'h123456);
		for (int k = 0; k < 11; k++)
			send_pixel(1'b1, 24'h0);
		drain_out();
		set_size(0, 3);
		send_pixel(1'b0, 24'hABCDEF);
		drain_out();
		set_size(4095, 1);
		for (int k = 0; k < 270; k++)
			send_pixel(1'b0, rand_rgb());
		drain_out();
		set_size(3, 0);
		send_pixel(1'b0, 24'h0);
		drain_out();
		set_size(1, 4);
		send_frame(1, 4, 1'b1, 1'b1);
		drain_out();
		set_size(7, 6);
		fork
			begin
				hold_off = 1'b1;
				repeat (120)
					@(posedge clk);
				hold_off = 1'b0;
			end
			send_frame(7, 6, 1'b0, 1'b0);
		join
		drain_out();
		set_size(1, 65535);
		for (int k = 0; k < 40; k++)
			send_pixel(1'b0, rand_rgb());
		drain_out();
		for (int f = 0; f < 14; f++) begin
			int unsigned fw, fh;
			fw = $urandom_range(1, 10);
			fh = $urandom_range(1, 8);
			set_size(fw, fh);
			send_frame(fw, fh, 1'b1, $urandom_range(0, 2) == 0);
			drain_out();
		end
		drain_out();
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== median_filter_5x5_rgb_top.f =====
rtl/mf5_pkg.sv
rtl/mf5_median.sv
rtl/median_filter_5x5_rgb_top.sv
rtl/mf5_checker.sv
bench/mf5_checker.sv
bench/tb_median_filter_5x5_rgb_top.sv
